### rtl/iss_pkg.sv
// Package for the insertion sorter: defaults and controller/datapath interface types.
package iss_pkg;

  localparam int unsigned MaxLenDefault = 16;

  // Commands from controller to datapath
  typedef struct packed {
    logic ins;    // insert the accepted item into the sorted chain
    logic pop;    // shift the chain down by one after a result is taken
  } iss_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;      // chain holds MAX_LEN elements
    logic one_left;  // exactly one element held
  } iss_sts_t;

endpackage

### rtl/iss_datapath.sv
// Datapath of the insertion sorter: systolic chain of sorted element cells and fill count.
module iss_datapath import iss_pkg::*; #(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iss_cmd_t           cmd_i,
  input  logic signed [31:0] value_i,
  output iss_sts_t           sts_o,
  output logic signed [31:0] head_o
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);

  logic signed [31:0] cell_q [MaxLen];
  logic signed [31:0] cell_d [MaxLen];
  logic [CntW-1:0]    count_q, count_d;
  logic [MaxLen-1:0]  gt;
  logic [MaxLen-1:0]  held;

  // Each held cell compares against the new item; held cells are sorted so gt is monotone.
  always_comb begin
    for (int i = 0; i < MaxLen; i++) begin
      held[i] = CntW'(i) < count_q;
      gt[i]   = held[i] && (cell_q[i] > value_i);
    end
  end

  always_comb begin
    for (int i = 0; i < MaxLen; i++) begin
      cell_d[i] = cell_q[i];
      if (cmd_i.ins) begin
        if (gt[i] || (CntW'(i) == count_q)) begin
          // take the neighbor's element if it moves up, else the new item
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
          end else begin
            cell_d[i] = value_i;
          end
        end
      end else if (cmd_i.pop) begin
        if (i < MaxLen - 1) begin
          cell_d[i] = cell_q[(i < MaxLen - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxLen; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

  assign sts_o.full     = (count_q == CntW'(MaxLen));
  assign sts_o.one_left = (count_q == CntW'(1));
  assign head_o         = cell_q[0];

endmodule

### rtl/iss_controller.sv
// Controller of the insertion sorter: load/emit state machine and overflow flag.
module iss_controller import iss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     last_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  iss_sts_t sts_i,
  output iss_cmd_t cmd_o,
  output logic     dropped_o
);

  typedef enum logic {
    StLoad,
    StEmit
  } state_e;

  state_e state_q;
  logic   overflow_q;
  logic   in_acc;
  logic   out_acc;

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = (state_q == StEmit);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  assign cmd_o.ins = in_acc && !sts_i.full;
  assign cmd_o.pop = out_acc;
  assign dropped_o = overflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      overflow_q <= 1'b0;
    end else begin
      case (state_q)
        StLoad: begin
          if (in_acc) begin
            if (sts_i.full) begin
              overflow_q <= 1'b1;
            end
            if (last_i) begin
              state_q <= StEmit;
            end
          end
        end
        StEmit: begin
          if (out_acc && sts_i.one_left) begin
            state_q    <= StLoad;
            overflow_q <= 1'b0;
          end
        end
        default: begin
          state_q <= StLoad;
        end
      endcase
    end
  end

endmodule

### rtl/insertion_sorter_top.sv
// Top level of the insertion sorter: controller and datapath.
// Items load at one per cycle; each is placed into a chain of MAX_LEN cells that stays
// sorted, all cells comparing against the item in the same cycle. The item flagged last
// closes the list, after which input is held off and the list drains one result per
// cycle while out_ready is high, ascending, with equal values in arrival order. Items
// beyond MAX_LEN are discarded and dropped is high on every result of that run;
// end_of_run marks the final result.
module insertion_sorter_top import iss_pkg::*; #(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] value_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sorted_value_o,
  output logic               end_of_run_o,
  output logic               dropped_o
);

  iss_cmd_t cmd;
  iss_sts_t sts;

  iss_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .dropped_o   (dropped_o)
  );

  iss_datapath #(
    .MaxLen (MaxLen)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .value_i (value_i),
    .sts_o   (sts),
    .head_o  (sorted_value_o)
  );

  assign end_of_run_o = sts.one_left;

endmodule

### rtl/iss_checker.sv
// Port-level assertions for the insertion sorter, bound to the top level.
module iss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               last_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] sorted_value_o,
  input logic               end_of_run_o,
  input logic               dropped_o
);

  // loading and draining never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while results pending");

  a_last_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> out_valid_o)
    else $error("no result after last item");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && end_of_run_o) |=> !out_valid_o)
    else $error("result after end of run");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !end_of_run_o) |=>
      (out_valid_o && (sorted_value_o >= $past(sorted_value_o))
       && (dropped_o == $past(dropped_o))))
    else $error("run out of order or dropped flag changed");

endmodule

bind insertion_sorter_top iss_checker u_iss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .last_i         (last_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sorted_value_o (sorted_value_o),
  .end_of_run_o   (end_of_run_o),
  .dropped_o      (dropped_o)
);
